[hw/rtl/mvna_pkg.sv]
// Shared types and constants for the mesh vertex normal accumulator.
// Request and result items, queue commands, state encodings.
// No dependencies.
`default_nettype none

package mvna_pkg;

	localparam int IDX_W       = 12;
	localparam int COORD_W     = 32;
	localparam int NORM_W      = 16;
	localparam int QUEUE_DEPTH = 4;

	// request action codes
	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_FACE  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]                action;
		logic [IDX_W-1:0]          vertex_index;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [IDX_W-1:0]          corner_a;
		logic [IDX_W-1:0]          corner_b;
		logic [IDX_W-1:0]          corner_c;
	} req_item_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic                     zero_length;
	} rsp_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} vec_t;

	// classified commands held in the queue
	typedef enum logic [1:0] {
		CMD_WRITE     = 2'd0,
		CMD_FACE      = 2'd1,
		CMD_READ      = 2'd2,
		CMD_READ_ZERO = 2'd3
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] ca;
		logic [IDX_W-1:0] cb;
		logic [IDX_W-1:0] cc;
		vec_t             pos;
	} cmd_t;

	// normalize unit result
	typedef struct packed {
		logic                     zero;
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
	} norm_res_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_MAX,
		N_SHIFT,
		N_SQ,
		N_SQRT,
		N_DIVINIT,
		N_DIV,
		N_DONE
	} norm_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_WRITE,
		B_FA,
		B_FB,
		B_FC,
		B_FE,
		B_MUL,
		B_NSTART,
		B_NWAIT,
		B_ARD,
		B_AWR,
		B_RRD,
		B_EMIT
	} back_state_t;

endpackage

`default_nettype wire

[hw/rtl/mvna_front.sv]
// Front end: decodes each request, checks indices and forms a queue command.
// Depends on mvna_pkg.
`default_nettype none

module mvna_front import mvna_pkg::*; #(
	parameter int MAX_VERTICES = 4096
) (
	input  req_item_t req,
	input  logic      req_valid,
	input  logic      q_full,
	output logic      push,
	output cmd_t      push_cmd
);

	logic vi_ok;
	logic face_ok;
	logic keep;

	// index range checks
	assign vi_ok = {{(32-IDX_W){1'b0}}, req.vertex_index} < 32'(MAX_VERTICES);
	assign face_ok = ({{(32-IDX_W){1'b0}}, req.corner_a} < 32'(MAX_VERTICES)) &&
	                 ({{(32-IDX_W){1'b0}}, req.corner_b} < 32'(MAX_VERTICES)) &&
	                 ({{(32-IDX_W){1'b0}}, req.corner_c} < 32'(MAX_VERTICES));

	// classify; requests that do nothing are dropped here
	always_comb begin
		keep          = 1'b0;
		push_cmd.op   = CMD_WRITE;
		push_cmd.idx  = req.vertex_index;
		push_cmd.ca   = req.corner_a;
		push_cmd.cb   = req.corner_b;
		push_cmd.cc   = req.corner_c;
		push_cmd.pos.x = req.pos_x;
		push_cmd.pos.y = req.pos_y;
		push_cmd.pos.z = req.pos_z;
		unique case (action_t'(req.action))
			ACT_WRITE: begin
				keep        = vi_ok;
				push_cmd.op = CMD_WRITE;
			end
			ACT_FACE: begin
				keep        = face_ok;
				push_cmd.op = CMD_FACE;
			end
			ACT_READ: begin
				keep        = 1'b1;
				push_cmd.op = vi_ok ? CMD_READ : CMD_READ_ZERO;
			end
			default: keep = 1'b0;
		endcase
	end

	assign push = req_valid && !q_full && keep;

endmodule

`default_nettype wire

[hw/rtl/mvna_queue.sv]
// Small command queue between the front end and the execution back end.
// Depends on mvna_pkg.
`default_nettype none

module mvna_queue import mvna_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/mvna_norm.sv]
// Iterative vector normalize unit: shift to range, sum of squares,
// bit-serial square root and restoring division to Q1.15. Depends on mvna_pkg.
`default_nettype none

module mvna_norm import mvna_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] vx,
	input  logic signed [63:0] vy,
	input  logic signed [63:0] vz,
	output logic               done,
	output norm_res_t          res
);

	norm_state_t state_q, state_d;

	logic                     neg_q [3];
	logic [63:0]              mag_q [3];
	logic [63:0]              m_q;
	logic                     zero_q;
	logic [59:0]              prod_q;
	logic [63:0]              sq_q;
	logic [1:0]               k_q;
	logic [63:0]              v_q;
	logic [63:0]              r_q;
	logic [4:0]               it_q;
	logic [30:0]              len_q;
	logic [16:0]              num_q;
	logic [30:0]              rem_q;
	logic [16:0]              quo_q;
	logic [4:0]               step_q;
	logic signed [NORM_W-1:0] n_q [3];

	logic [63:0] mx;
	logic        big8, big1, small8, small1, in_range;
	logic [63:0] sbit, trial, r_nx, v_nx;
	logic        take;
	logic [45:0] num_init;
	logic [31:0] trem;
	logic        ge;
	logic [16:0] quo_nx;
	logic [15:0] qc;

	// largest magnitude
	always_comb begin
		mx = mag_q[0];
		if (mag_q[1] > mx) mx = mag_q[1];
		if (mag_q[2] > mx) mx = mag_q[2];
	end

	// range tests for the shift step
	assign big8     = |m_q[63:38];
	assign big1     = |m_q[63:30];
	assign small8   = ~|m_q[63:21];
	assign small1   = ~|m_q[63:29];
	assign in_range = !big1 && !small1;

	// one square root step
	assign sbit  = 64'd1 << {it_q, 1'b0};
	assign trial = r_q + sbit;
	assign take  = v_q >= trial;
	assign r_nx  = take ? (r_q >> 1) + sbit : r_q >> 1;
	assign v_nx  = take ? v_q - trial : v_q;

	// division setup and one quotient bit
	assign num_init = 46'({mag_q[k_q][29:0], 15'd0}) + 46'(len_q[30:1]);
	assign trem     = {rem_q, num_q[step_q]};
	assign ge       = trem >= {1'b0, len_q};
	assign quo_nx   = {quo_q[15:0], ge};
	assign qc       = (quo_nx > 17'd32767) ? 16'd32767 : quo_nx[15:0];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= N_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			N_IDLE:    if (start) state_d = N_MAX;
			N_MAX:     state_d = N_SHIFT;
			N_SHIFT: begin
				if (zero_q) state_d = N_DONE;
				else if (in_range) state_d = N_SQ;
			end
			N_SQ:      if (k_q == 2'd3) state_d = N_SQRT;
			N_SQRT:    if (it_q == '0) state_d = N_DIVINIT;
			N_DIVINIT: state_d = N_DIV;
			N_DIV: begin
				if (step_q == '0) state_d = (k_q == 2'd2) ? N_DONE : N_DIVINIT;
			end
			N_DONE:    state_d = N_IDLE;
			default:   state_d = N_IDLE;
		endcase
	end

	assign done    = state_q == N_DONE;
	assign res.zero = zero_q;
	assign res.nx   = n_q[0];
	assign res.ny   = n_q[1];
	assign res.nz   = n_q[2];

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					neg_q[0] <= vx[63];
					neg_q[1] <= vy[63];
					neg_q[2] <= vz[63];
					mag_q[0] <= vx[63] ? 64'd0 - vx : vx;
					mag_q[1] <= vy[63] ? 64'd0 - vy : vy;
					mag_q[2] <= vz[63] ? 64'd0 - vz : vz;
				end
			end
			N_MAX: begin
				m_q    <= mx;
				zero_q <= mx == '0;
				n_q[0] <= '0;
				n_q[1] <= '0;
				n_q[2] <= '0;
			end
			N_SHIFT: begin
				if (!zero_q) begin
					if (big8) begin
						m_q      <= m_q >> 8;
						mag_q[0] <= mag_q[0] >> 8;
						mag_q[1] <= mag_q[1] >> 8;
						mag_q[2] <= mag_q[2] >> 8;
					end else if (big1) begin
						m_q      <= m_q >> 1;
						mag_q[0] <= mag_q[0] >> 1;
						mag_q[1] <= mag_q[1] >> 1;
						mag_q[2] <= mag_q[2] >> 1;
					end else if (small8) begin
						m_q      <= m_q << 8;
						mag_q[0] <= mag_q[0] << 8;
						mag_q[1] <= mag_q[1] << 8;
						mag_q[2] <= mag_q[2] << 8;
					end else if (small1) begin
						m_q      <= m_q << 1;
						mag_q[0] <= mag_q[0] << 1;
						mag_q[1] <= mag_q[1] << 1;
						mag_q[2] <= mag_q[2] << 1;
					end
				end
				sq_q <= '0;
				k_q  <= '0;
			end
			N_SQ: begin
				if (k_q != 2'd3) prod_q <= mag_q[k_q][29:0] * mag_q[k_q][29:0];
				if (k_q != 2'd0 && k_q != 2'd3) sq_q <= sq_q + 64'(prod_q);
				if (k_q == 2'd3) begin
					v_q  <= sq_q + 64'(prod_q);
					r_q  <= '0;
					it_q <= 5'd31;
					k_q  <= '0;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			N_SQRT: begin
				v_q <= v_nx;
				r_q <= r_nx;
				if (it_q == '0) len_q <= r_nx[30:0];
				else            it_q  <= it_q - 5'd1;
			end
			N_DIVINIT: begin
				num_q  <= num_init[16:0];
				rem_q  <= 31'(num_init[45:17]);
				quo_q  <= '0;
				step_q <= 5'd16;
			end
			N_DIV: begin
				rem_q <= ge ? 31'(trem - {1'b0, len_q}) : trem[30:0];
				quo_q <= quo_nx;
				if (step_q == '0) begin
					n_q[k_q] <= neg_q[k_q] ? $signed(16'd0 - qc) : $signed(qc);
					k_q      <= k_q + 2'd1;
				end else begin
					step_q <= step_q - 5'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/mvna_back.sv]
// Execution back end: vertex and accumulator memories, face cross product,
// saturating accumulator updates, normal reads and the result register.
// Depends on mvna_pkg and mvna_norm.
`default_nettype none

module mvna_back import mvna_pkg::*; #(
	parameter int MAX_VERTICES = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  logic      empty,
	output logic      pop,
	output rsp_item_t rsp,
	output logic      rsp_valid,
	input  logic      rsp_stall
);

	localparam int AW = $clog2(MAX_VERTICES);

	back_state_t state_q, state_d;

	vec_t vmem [MAX_VERTICES];
	vec_t amem [MAX_VERTICES];

	cmd_t                      cmd_q;
	vec_t                      vrd_q;
	vec_t                      ard_q;
	vec_t                      pa_q;
	vec_t                      pb_q;
	logic signed [COORD_W-1:0] e1_q [3];
	logic signed [COORD_W-1:0] e2_q [3];
	logic signed [63:0]        prod_q;
	logic signed [63:0]        cr_q [3];
	logic [2:0]                cnt_q;
	logic [1:0]                corner_q;
	norm_res_t                 nres_q;
	rsp_item_t                 rsp_q;
	logic                      rsp_valid_q;

	logic [AW-1:0]             v_raddr;
	logic [AW-1:0]             a_raddr;
	logic [AW-1:0]             a_waddr;
	logic [AW-1:0]             corner_addr;
	logic                      v_we;
	logic                      a_we;
	vec_t                      a_wdata;
	logic signed [COORD_W-1:0] mul_a;
	logic signed [COORD_W-1:0] mul_b;
	logic                      emit_ok;
	logic                      n_start;
	logic                      n_done;
	norm_res_t                 n_res;
	logic signed [63:0]        n_vx, n_vy, n_vz;

	function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] idx);
		return AW'(idx);
	endfunction

	// edge difference clipped to +-(2^31 - 1)
	function automatic logic signed [COORD_W-1:0] sat_edge(
		input logic signed [COORD_W-1:0] hi,
		input logic signed [COORD_W-1:0] lo
	);
		logic signed [COORD_W:0] d;
		d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
		if (d > 33'sd2147483647) return 32'sd2147483647;
		if (d < -33'sd2147483647) return -32'sd2147483647;
		return d[COORD_W-1:0];
	endfunction

	// accumulator add with saturation
	function automatic logic signed [COORD_W-1:0] sat_add(
		input logic signed [COORD_W-1:0] acc,
		input logic signed [NORM_W-1:0]  n
	);
		logic signed [COORD_W:0] s;
		s = {acc[COORD_W-1], acc} + {{(COORD_W-NORM_W+1){n[NORM_W-1]}}, n};
		if (s[COORD_W] != s[COORD_W-1])
			return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		return s[COORD_W-1:0];
	endfunction

	assign pop     = (state_q == B_IDLE) && !empty;
	assign emit_ok = !rsp_valid_q || !rsp_stall;
	assign n_start = state_q == B_NSTART;

	// corner address for accumulator updates
	always_comb begin
		case (corner_q)
			2'd0:    corner_addr = addr_of(cmd_q.ca);
			2'd1:    corner_addr = addr_of(cmd_q.cb);
			default: corner_addr = addr_of(cmd_q.cc);
		endcase
	end

	// memory address and write control
	always_comb begin
		case (state_q)
			B_FB:    v_raddr = addr_of(cmd_q.cb);
			B_FC:    v_raddr = addr_of(cmd_q.cc);
			default: v_raddr = addr_of(cmd_q.ca);
		endcase
		a_raddr = (state_q == B_RRD) ? addr_of(cmd_q.idx) : corner_addr;
		v_we    = state_q == B_WRITE;
		a_we    = (state_q == B_WRITE) || (state_q == B_AWR);
		a_waddr = (state_q == B_WRITE) ? addr_of(cmd_q.idx) : corner_addr;
		if (state_q == B_WRITE) begin
			a_wdata = '0;
		end else begin
			a_wdata.x = sat_add(ard_q.x, nres_q.nx);
			a_wdata.y = sat_add(ard_q.y, nres_q.ny);
			a_wdata.z = sat_add(ard_q.z, nres_q.nz);
		end
	end

	// vertex store
	always_ff @(posedge clk) begin
		if (v_we) vmem[addr_of(cmd_q.idx)] <= cmd_q.pos;
		vrd_q <= vmem[v_raddr];
	end

	// accumulator store
	always_ff @(posedge clk) begin
		if (a_we) amem[a_waddr] <= a_wdata;
		ard_q <= amem[a_raddr];
	end

	// multiplier operand selection for the cross product terms
	always_comb begin
		case (cnt_q)
			3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
			3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
			3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
			3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
			3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
			default: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
		endcase
	end

	// normalize input: cross product for faces, accumulator for reads
	always_comb begin
		if (cmd_q.op == CMD_FACE) begin
			n_vx = cr_q[0];
			n_vy = cr_q[1];
			n_vz = cr_q[2];
		end else begin
			n_vx = {{32{ard_q.x[COORD_W-1]}}, ard_q.x};
			n_vy = {{32{ard_q.y[COORD_W-1]}}, ard_q.y};
			n_vz = {{32{ard_q.z[COORD_W-1]}}, ard_q.z};
		end
	end

	mvna_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (n_start),
		.vx     (n_vx),
		.vy     (n_vy),
		.vz     (n_vz),
		.done   (n_done),
		.res    (n_res)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!empty) begin
					unique case (cmd.op)
						CMD_WRITE:     state_d = B_WRITE;
						CMD_FACE:      state_d = B_FA;
						CMD_READ:      state_d = B_RRD;
						CMD_READ_ZERO: state_d = B_EMIT;
						default:       state_d = B_IDLE;
					endcase
				end
			end
			B_WRITE:  state_d = B_IDLE;
			B_FA:     state_d = B_FB;
			B_FB:     state_d = B_FC;
			B_FC:     state_d = B_FE;
			B_FE:     state_d = B_MUL;
			B_MUL:    if (cnt_q == 3'd6) state_d = B_NSTART;
			B_NSTART: state_d = B_NWAIT;
			B_NWAIT: begin
				if (n_done) begin
					if (cmd_q.op == CMD_READ) state_d = B_EMIT;
					else if (n_res.zero)      state_d = B_IDLE;
					else                      state_d = B_ARD;
				end
			end
			B_ARD:    state_d = B_AWR;
			B_AWR:    state_d = (corner_q == 2'd2) ? B_IDLE : B_ARD;
			B_RRD:    state_d = B_NSTART;
			B_EMIT:   if (emit_ok) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			corner_q <= '0;
		end else begin
			if (state_q == B_FE)       cnt_q <= '0;
			else if (state_q == B_MUL) cnt_q <= cnt_q + 3'd1;
			if (state_q == B_NWAIT)    corner_q <= '0;
			else if (state_q == B_AWR) corner_q <= corner_q + 2'd1;
		end
	end

	// face datapath and command capture
	always_ff @(posedge clk) begin
		if (pop) cmd_q <= cmd;
		if (pop && cmd.op == CMD_READ_ZERO) begin
			nres_q.zero <= 1'b1;
			nres_q.nx   <= '0;
			nres_q.ny   <= '0;
			nres_q.nz   <= '0;
		end
		if (state_q == B_NWAIT && n_done) nres_q <= n_res;
		if (state_q == B_FB) pa_q <= vrd_q;
		if (state_q == B_FC) pb_q <= vrd_q;
		if (state_q == B_FE) begin
			e1_q[0] <= sat_edge(pb_q.x, pa_q.x);
			e1_q[1] <= sat_edge(pb_q.y, pa_q.y);
			e1_q[2] <= sat_edge(pb_q.z, pa_q.z);
			e2_q[0] <= sat_edge(vrd_q.x, pb_q.x);
			e2_q[1] <= sat_edge(vrd_q.y, pb_q.y);
			e2_q[2] <= sat_edge(vrd_q.z, pb_q.z);
		end
		if (state_q == B_MUL) begin
			prod_q <= mul_a * mul_b;
			case (cnt_q)
				3'd1:    cr_q[0] <= prod_q;
				3'd2:    cr_q[0] <= cr_q[0] - prod_q;
				3'd3:    cr_q[1] <= prod_q;
				3'd4:    cr_q[1] <= cr_q[1] - prod_q;
				3'd5:    cr_q[2] <= prod_q;
				3'd6:    cr_q[2] <= cr_q[2] - prod_q;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == B_EMIT && emit_ok) begin
			rsp_q.normal_x    <= nres_q.nx;
			rsp_q.normal_y    <= nres_q.ny;
			rsp_q.normal_z    <= nres_q.nz;
			rsp_q.zero_length <= nres_q.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                           rsp_valid_q <= 1'b0;
		else if (state_q == B_EMIT && emit_ok) rsp_valid_q <= 1'b1;
		else if (!rsp_stall)                   rsp_valid_q <= 1'b0;
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

[hw/rtl/mesh_vertex_normal_accumulator.sv]
// Mesh vertex normal accumulator, top level.
// Joins front end, command queue and back end. Depends on mvna_pkg,
// mvna_front, mvna_queue and mvna_back.
//
// Usage:
//   req/req_valid/req_stall carry requests: write a vertex (stores the
//   position, clears its normal sum), add a face (unit face normal added to
//   its three corners with saturation) or read a vertex normal.
//   rsp/rsp_valid/rsp_stall carry one result per read request.
//   A four-entry command queue sits between the decoder and the sequencer;
//   req_stall rises only when that queue is full.
//   Once a request reaches the sequencer, a write stores the vertex, a
//   face runs cross product, normalize and corner updates, and a read
//   normalizes the sum into the result register. Out-of-range writes, faces
//   with an out-of-range corner and unused action codes are dropped at decode.
//   Face and read time is set by the normalize unit: a 32-step square root
//   and three 17-step quotient divisions, plus a six-product cross product
//   on a single shared multiplier. One request is executed at a time.
//   Reset empties the queue and result register; vertex and normal stores
//   are not cleared, a vertex is defined once written.
//   While rsp_stall is high the result holds; the sequencer waits with its
//   next result but the queue keeps taking requests until full.
`default_nettype none

module mesh_vertex_normal_accumulator import mvna_pkg::*; #(
	parameter int MAX_VERTICES = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t req,
	input  logic      req_valid,
	output logic      req_stall,
	output rsp_item_t rsp,
	output logic      rsp_valid,
	input  logic      rsp_stall
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	assign req_stall = q_full;

	mvna_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
		.req       (req),
		.req_valid (req_valid),
		.q_full    (q_full),
		.push      (q_push),
		.push_cmd  (push_cmd)
	);

	mvna_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	mvna_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (pop_cmd),
		.empty     (q_empty),
		.pop       (q_pop),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

`default_nettype wire

[hw/rtl/mvna_checker.sv]
// Port-level checks for the mesh vertex normal accumulator, bound to the top.
// Depends on mvna_pkg and mesh_vertex_normal_accumulator.
`default_nettype none

module mvna_checker import mvna_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input req_item_t req,
	input logic      req_valid,
	input logic      req_stall,
	input rsp_item_t rsp,
	input logic      rsp_valid,
	input logic      rsp_stall
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// zero flag comes with all-zero components
	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.zero_length |->
			rsp.normal_x == '0 && rsp.normal_y == '0 && rsp.normal_z == '0)
		else $error("zero-length result with nonzero component");

	// a unit normal has at least one nonzero component
	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.zero_length |->
			rsp.normal_x != '0 || rsp.normal_y != '0 || rsp.normal_z != '0)
		else $error("unit normal with all components zero");

	// no result during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("result valid during reset");

endmodule

bind mesh_vertex_normal_accumulator mvna_checker u_mvna_checker (.*);

`default_nettype wire
